>>> hdl/prls_pkg.sv
// prls_pkg: shared widths and codes for the ready-list scheduler
// used by the channel interfaces and the top level, depends on nothing

package prls_pkg;

   localparam int MODE_W   = 2;
   localparam int PROC_ID_W = 8;
   localparam int PRIO_W   = 8;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef logic [MODE_W-1:0]   op_type;
   typedef logic [MODE_W-1:0]   sched_type;
   typedef logic [STATUS_W-1:0] status_type;

   // operation codes of an input beat
   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_REMOVE = 2'd1;
   localparam op_type OP_UPDATE = 2'd2;

   // scheduler_mode register codes
   localparam sched_type SCHED_FIRST_RUN = 2'd0;
   localparam sched_type SCHED_HEAD      = 2'd1;
   localparam sched_type SCHED_LOWEST    = 2'd2;
   localparam sched_type SCHED_NONE      = 2'd3;

   // result status codes
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_FULL      = 2'd1;
   localparam status_type ST_NOT_FOUND = 2'd2;

endpackage

>>> hdl/prls_req_if.sv
// prls_req_if: valid/ready channel carrying one scheduler request beat
// depends on prls_pkg for field widths

interface prls_req_if import prls_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [PROC_ID_W-1:0] proc_id;
   logic [PRIO_W-1:0]    priority_req;
   logic                 running;

   modport source (output valid, mode, proc_id, priority_req, running, input ready);
   modport sink   (input valid, mode, proc_id, priority_req, running, output ready);
endinterface

>>> hdl/prls_rsp_if.sv
// prls_rsp_if: valid/ready channel carrying one scheduler result beat
// depends on prls_pkg for field widths

interface prls_rsp_if import prls_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 pick_valid;
   logic [PROC_ID_W-1:0] pick_id;
   logic [COUNT_W-1:0]   entry_count;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, pick_valid, pick_id, entry_count, status, input ready);
   modport sink   (input valid, pick_valid, pick_id, entry_count, status, output ready);
endinterface

>>> hdl/process_ready_list_scheduler.sv
// Ready-list scheduler. Keeps an ordered list of up to MAX_ENTRIES process
// ids with a priority and running flag each, in one ram scanned one entry per
// cycle. An insert walks the single ram read port once, to choose the pick;
// an update walks it once to find the id and once more to choose the pick;
// a remove walks it once to find the id, once more to close the gap, and
// once to choose the pick. The request side is not ready until
// the result is in the output register; a result waiting there does not block
// the next request. No clearing pass is needed after reset.
// Depends on prls_pkg, prls_req_if, prls_rsp_if and prls_ram.

module process_ready_list_scheduler import prls_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int ID_BITS     = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [MODE_W-1:0] csr_wr_data,
   prls_req_if.sink          req_chan,
   prls_rsp_if.source        rsp_chan
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = ID_BITS + PRIO_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_SHIFT,
      S_PICK,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   sched_type           sched_ff, sched_in;
   logic [CW-1:0]       count_ff, count_in;
   op_type              op_ff, op_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;
   logic                run_ff, run_in;
   status_type          status_ff, status_in;
   logic [CW-1:0]       scan_addr_ff, scan_addr_in;
   logic                data_vld_ff, data_vld_in;
   logic [IW-1:0]       data_idx_ff, data_idx_in;
   logic                best_vld_ff, best_vld_in;
   logic [ID_BITS-1:0]  best_id_ff, best_id_in;
   logic [PRIO_W-1:0]   best_prio_ff, best_prio_in;
   logic                best_run_ff, best_run_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_pick_valid_ff, rsp_pick_valid_in;
   logic [PROC_ID_W-1:0] rsp_pick_id_ff, rsp_pick_id_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic                ram_wr_en;
   logic [IW-1:0]       ram_wr_addr;
   logic [EW-1:0]       ram_wr_data;
   logic                ram_rd_en;
   logic [EW-1:0]       ram_rd_data;
   logic [ID_BITS-1:0]  rd_id;
   logic [PRIO_W-1:0]   rd_prio;
   logic                rd_run;
   logic                issue;
   logic                scan_end;
   logic                take;

   prls_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_addr_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   // entry layout: {id, priority, running}
   assign rd_id   = ram_rd_data[EW-1 -: ID_BITS];
   assign rd_prio = ram_rd_data[PRIO_W:1];
   assign rd_run  = ram_rd_data[0];

   assign issue    = scan_addr_ff < count_ff;
   assign scan_end = !data_vld_ff && !issue;
   assign take     = !best_vld_ff
                     || (sched_ff == SCHED_FIRST_RUN && !best_run_ff && rd_run)
                     || (sched_ff == SCHED_LOWEST && rd_prio < best_prio_ff);

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pick_valid  = rsp_pick_valid_ff;
   assign rsp_chan.pick_id     = rsp_pick_id_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.status      = rsp_status_ff;

   always_comb begin
      state_in          = state_ff;
      sched_in          = csr_wr_en ? csr_wr_data : sched_ff;
      count_in          = count_ff;
      op_in             = op_ff;
      id_in             = id_ff;
      prio_in           = prio_ff;
      run_in            = run_ff;
      status_in         = status_ff;
      scan_addr_in      = scan_addr_ff;
      data_vld_in       = data_vld_ff;
      data_idx_in       = data_idx_ff;
      best_vld_in       = best_vld_ff;
      best_id_in        = best_id_ff;
      best_prio_in      = best_prio_ff;
      best_run_in       = best_run_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_pick_valid_in = rsp_pick_valid_ff;
      rsp_pick_id_in    = rsp_pick_id_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_status_in     = rsp_status_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = data_idx_ff;
      ram_wr_data       = ram_rd_data;
      ram_rd_en         = 1'b0;

      // scan engine: one read issued per cycle, its data checked in the next cycle
      if (state_ff == S_FIND || state_ff == S_SHIFT || state_ff == S_PICK) begin
         ram_rd_en   = issue;
         data_vld_in = issue;
         if (issue) begin
            scan_addr_in = scan_addr_ff + CW'(1);
            data_idx_in  = scan_addr_ff[IW-1:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            scan_addr_in = '0;
            data_vld_in  = 1'b0;
            best_vld_in  = 1'b0;
            if (req_chan.valid) begin
               op_in     = req_chan.mode;
               id_in     = ID_BITS'(req_chan.proc_id);
               prio_in   = req_chan.priority_req;
               run_in    = req_chan.running;
               status_in = ST_OK;
               state_in  = S_PICK;
               case (req_chan.mode) inside
                  OP_INSERT: begin
                     if (count_ff == CW'(MAX_ENTRIES)) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[IW-1:0];
                        ram_wr_data = {ID_BITS'(req_chan.proc_id), req_chan.priority_req,
                                       req_chan.running};
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  OP_REMOVE, OP_UPDATE: begin
                     state_in = S_FIND;
                  end
                  default: begin
                     state_in = S_PICK;
                  end
               endcase
            end
         end
         S_FIND: begin
            if (data_vld_ff && rd_id == id_ff) begin
               data_vld_in = 1'b0;
               if (op_ff == OP_UPDATE) begin
                  ram_wr_en    = 1'b1;
                  ram_wr_data  = {rd_id, prio_ff, run_ff};
                  scan_addr_in = '0;
                  best_vld_in  = 1'b0;
                  state_in     = S_PICK;
               end else begin
                  // close the gap starting just after the match
                  scan_addr_in = CW'(data_idx_ff) + CW'(1);
                  state_in     = S_SHIFT;
               end
            end else if (scan_end) begin
               status_in    = ST_NOT_FOUND;
               scan_addr_in = '0;
               best_vld_in  = 1'b0;
               state_in     = S_PICK;
            end
         end
         S_SHIFT: begin
            if (data_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = data_idx_ff - IW'(1);
            end
            if (scan_end) begin
               count_in     = count_ff - CW'(1);
               scan_addr_in = '0;
               best_vld_in  = 1'b0;
               state_in     = S_PICK;
            end
         end
         S_PICK: begin
            if (data_vld_ff && take) begin
               best_vld_in  = 1'b1;
               best_id_in   = rd_id;
               best_prio_in = rd_prio;
               best_run_in  = rd_run;
            end
            if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_pick_valid_in = best_vld_ff && sched_ff != SCHED_NONE;
               rsp_pick_id_in    = (best_vld_ff && sched_ff != SCHED_NONE)
                                   ? PROC_ID_W'(best_id_ff) : '0;
               rsp_count_in      = COUNT_W'(count_ff);
               rsp_status_in     = status_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sched_ff     <= SCHED_FIRST_RUN;
         count_ff     <= '0;
         data_vld_ff  <= 1'b0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff          <= state_in;
         sched_ff          <= sched_in;
         count_ff          <= count_in;
         op_ff             <= op_in;
         id_ff             <= id_in;
         prio_ff           <= prio_in;
         run_ff            <= run_in;
         status_ff         <= status_in;
         scan_addr_ff      <= scan_addr_in;
         data_vld_ff       <= data_vld_in;
         data_idx_ff       <= data_idx_in;
         best_vld_ff       <= best_vld_in;
         best_id_ff        <= best_id_in;
         best_prio_ff      <= best_prio_in;
         best_run_ff       <= best_run_in;
         rsp_valid_ff      <= rsp_valid_in;
         rsp_pick_valid_ff <= rsp_pick_valid_in;
         rsp_pick_id_ff    <= rsp_pick_id_in;
         rsp_count_ff      <= rsp_count_in;
         rsp_status_ff     <= rsp_status_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond list depth");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request taken while previous one still in work");

   a_no_pick_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pick_valid_ff |-> rsp_pick_id_ff == '0)
      else $error("nonzero id reported without a pick");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && req_chan.valid && req_chan.mode == OP_INSERT
      && count_ff == CW'(MAX_ENTRIES) |=> status_ff == ST_FULL && count_ff == $past(count_ff))
      else $error("insert into full list not dropped");

endmodule

>>> hdl/prls_ram.sv
// prls_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module prls_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> bench/tb_process_ready_list_scheduler.sv
// tb_process_ready_list_scheduler: self-checking bench for the ready-list scheduler,
// tracks the list in its own copy and checks each pick beat against it
// depends on prls_pkg, prls_req_if, prls_rsp_if and process_ready_list_scheduler

module tb_process_ready_list_scheduler import prls_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH     = 16;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;

   // request code the block leaves alone
   localparam op_type OP_IDLE = 2'd3;

   typedef struct packed {
      op_type               op;
      logic [PROC_ID_W-1:0] proc_id;
      logic [PRIO_W-1:0]    prio;
      logic                 run;
   } sched_req_type;

   typedef struct packed {
      logic                 pick_valid;
      logic [PROC_ID_W-1:0] pick_id;
      logic [COUNT_W-1:0]   entry_count;
      status_type           status;
   } pick_result_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [MODE_W-1:0] csr_wr_data;

   prls_req_if req_chan ();
   prls_rsp_if rsp_chan ();

   process_ready_list_scheduler u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // shadow of the ready list and the mode register
   logic [PROC_ID_W-1:0] rl_id   [LIST_DEPTH];
   logic [PRIO_W-1:0]    rl_prio [LIST_DEPTH];
   logic                 rl_run  [LIST_DEPTH];
   int                   rl_len;
   sched_type            sched_mode_q;

   pick_result_type pending_picks[$];

   int  error_count;
   int  request_count;
   int  result_count;
   int  full_drops;
   int  absent_ids;
   int  empty_picks;
   bit  idle_enabled;
   bit  hold_request;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic sched_req_type make_beat(op_type op, logic [PROC_ID_W-1:0] id,
                                               logic [PRIO_W-1:0] prio, logic run);
      sched_req_type b;
      b.op      = op;
      b.proc_id = id;
      b.prio    = prio;
      b.run     = run;
      return b;
   endfunction

   // applies one request to the shadow list and returns the pick that follows
   function automatic pick_result_type apply_to_ready_list(sched_req_type b);
      pick_result_type r;
      int              pos;
      int              sel;
      r        = '0;
      r.status = ST_OK;
      pos      = rl_len;
      for (int i = rl_len - 1; i >= 0; i--)
         if (rl_id[i] == b.proc_id) pos = i;
      case (b.op)
         OP_INSERT: begin
            if (rl_len >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               rl_id[rl_len]   = b.proc_id;
               rl_prio[rl_len] = b.prio;
               rl_run[rl_len]  = b.run;
               rl_len++;
            end
         end
         OP_REMOVE: begin
            if (pos >= rl_len) begin
               r.status = ST_NOT_FOUND;
            end else begin
               for (int i = pos; i + 1 < rl_len; i++) begin
                  rl_id[i]   = rl_id[i+1];
                  rl_prio[i] = rl_prio[i+1];
                  rl_run[i]  = rl_run[i+1];
               end
               rl_len--;
            end
         end
         OP_UPDATE: begin
            if (pos >= rl_len) begin
               r.status = ST_NOT_FOUND;
            end else begin
               rl_prio[pos] = b.prio;
               rl_run[pos]  = b.run;
            end
         end
         default: ;
      endcase
      sel = -1;
      if (rl_len > 0) begin
         case (sched_mode_q)
            SCHED_FIRST_RUN: begin
               sel = 0;
               for (int i = rl_len - 1; i >= 0; i--)
                  if (rl_run[i]) sel = i;
            end
            SCHED_HEAD: sel = 0;
            SCHED_LOWEST: begin
               sel = 0;
               for (int i = 1; i < rl_len; i++)
                  if (rl_prio[i] < rl_prio[sel]) sel = i;
            end
            default: sel = -1;
         endcase
      end
      if (sel >= 0) begin
         r.pick_valid = 1'b1;
         r.pick_id    = rl_id[sel];
      end
      r.entry_count = COUNT_W'(rl_len);
      return r;
   endfunction

   // mostly well-formed traffic that keeps ids live, plus some noise
   function automatic sched_req_type draw_sched_beat();
      sched_req_type b;
      int            ins_pct;
      b.prio    = ($urandom_range(0, 1) == 1) ? PRIO_W'($urandom_range(0, 7))
                                              : PRIO_W'($urandom);
      b.run     = 1'($urandom_range(0, 1));
      b.proc_id = ($urandom_range(0, 3) == 0) ? PROC_ID_W'($urandom)
                                              : PROC_ID_W'($urandom_range(0, 23));
      if ($urandom_range(0, 99) < 6) begin
         b.op      = op_type'($urandom_range(0, 3));
         b.proc_id = PROC_ID_W'($urandom);
         return b;
      end
      ins_pct = (rl_len < 4) ? 70 : (rl_len > 12) ? 25 : 45;
      if ($urandom_range(0, 99) < ins_pct) begin
         b.op = OP_INSERT;
      end else begin
         b.op = ($urandom_range(0, 1) == 1) ? OP_REMOVE : OP_UPDATE;
         if (rl_len > 0 && $urandom_range(0, 99) < 85)
            b.proc_id = rl_id[$urandom_range(0, rl_len - 1)];
      end
      return b;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %0h want %0h", result_count, what, got, want);
      error_count++;
   endtask

   task automatic send_request(sched_req_type b);
      int gap;
      gap = idle_enabled ? $urandom_range(0, 10) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= b.op;
      req_chan.proc_id      <= b.proc_id;
      req_chan.priority_req <= b.prio;
      req_chan.running      <= b.run;
      do @(posedge clock); while (!req_chan.ready);
      pending_picks.push_back(apply_to_ready_list(b));
      request_count++;
   endtask

   task automatic wait_for_picks();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sched_mode(sched_type m);
      wait_for_picks();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sched_mode_q = m;
   endtask

   task automatic test_empty_list();
      send_request(make_beat(OP_REMOVE, 8'h05, 8'h10, 1'b0));
      send_request(make_beat(OP_UPDATE, 8'h05, 8'h10, 1'b1));
      send_request(make_beat(OP_IDLE, 8'h00, 8'h00, 1'b0));
   endtask

   task automatic test_extremes_and_duplicates();
      send_request(make_beat(OP_INSERT, 8'hFF, 8'hFF, 1'b0));
      send_request(make_beat(OP_INSERT, 8'h00, 8'h00, 1'b1));
      send_request(make_beat(OP_INSERT, 8'hFF, 8'h80, 1'b0));
      // both act on the first of the two 0xff entries
      send_request(make_beat(OP_UPDATE, 8'hFF, 8'h01, 1'b1));
      send_request(make_beat(OP_REMOVE, 8'hFF, 8'h00, 1'b0));
      send_request(make_beat(OP_IDLE, 8'hFF, 8'hFF, 1'b1));
      send_request(make_beat(OP_REMOVE, 8'h55, 8'hAA, 1'b1));
   endtask

   task automatic test_full_list();
      for (int i = 0; i < LIST_DEPTH - 2; i++)
         send_request(make_beat(OP_INSERT, PROC_ID_W'(8'hA0 + i), PRIO_W'(i * 17),
                                1'(i)));
      send_request(make_beat(OP_INSERT, 8'hFF, 8'h00, 1'b1));
   endtask

   task automatic test_random_phase(sched_type m, int count);
      write_sched_mode(m);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
         send_request(draw_sched_beat());
      end
   endtask

   // sink stops for a long stretch while requests keep coming back to back
   task automatic test_receiver_holdoff();
      idle_enabled = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++)
         send_request(draw_sched_beat());
      idle_enabled = 1'b1;
   endtask

   task automatic test_sender_drain_pause();
      idle_enabled = 1'b1;
      for (int i = 0; i < 30; i++)
         send_request(draw_sched_beat());
      wait_for_picks();
      for (int i = 0; i < 30; i++)
         send_request(draw_sched_beat());
   endtask

   // result side: random stalls, long hold on request, compare each beat
   initial begin : pick_sink
      int              stall;
      int              hold_left;
      pick_result_type want;
      stall         = 0;
      hold_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            if (pending_picks.size() == 0) begin
               report_mismatch("beat with nothing pending", 32'(rsp_chan.pick_id), 0);
            end else begin
               want = pending_picks.pop_front();
               if (want.status == ST_FULL) full_drops++;
               if (want.status == ST_NOT_FOUND) absent_ids++;
               if (!want.pick_valid) empty_picks++;
               if (rsp_chan.pick_valid !== want.pick_valid)
                  report_mismatch("pick_valid", 32'(rsp_chan.pick_valid),
                                  32'(want.pick_valid));
               if (rsp_chan.pick_id !== want.pick_id)
                  report_mismatch("pick_id", 32'(rsp_chan.pick_id), 32'(want.pick_id));
               if (rsp_chan.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_chan.entry_count),
                                  32'(want.entry_count));
               if (rsp_chan.status !== want.status)
                  report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
            end
            stall = idle_enabled ? $urandom_range(0, 10) : 0;
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_chan.valid        = 1'b0;
      req_chan.mode         = '0;
      req_chan.proc_id      = '0;
      req_chan.priority_req = '0;
      req_chan.running      = 1'b0;
      rl_len                = 0;
      sched_mode_q          = SCHED_FIRST_RUN;
      error_count           = 0;
      request_count         = 0;
      result_count          = 0;
      full_drops            = 0;
      absent_ids            = 0;
      empty_picks           = 0;
      idle_enabled          = 1'b1;
      hold_request          = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_extremes_and_duplicates();
      test_full_list();
      test_random_phase(SCHED_HEAD, 220);
      test_receiver_holdoff();
      test_random_phase(SCHED_LOWEST, 220);
      test_sender_drain_pause();
      test_random_phase(SCHED_NONE, 150);
      test_random_phase(SCHED_FIRST_RUN, 220);
      test_receiver_holdoff();
      test_random_phase(SCHED_LOWEST, 200);

      wait_for_picks();
      $display("covered %0d requests and %0d picks across all four scheduler modes",
               request_count, result_count);
      $display("  %0d inserts dropped on a full list, %0d absent ids, %0d beats with no pick",
               full_drops, absent_ids, empty_picks);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
